// ----- sv/islip_crossbar_scheduler_defines.svh -----
// ----------------------------------------------------------------------------
// islip_crossbar_scheduler_defines
// Assertion macros shared by the scheduler modules.
// Both expect signals named clk and arst_n in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef ISLIP_CROSSBAR_SCHEDULER_DEFINES_SVH
`define ISLIP_CROSSBAR_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISLIP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISLIP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/islip_pkg.sv -----
// ----------------------------------------------------------------------------
// islip_pkg
// Shared sizes, register map, command and status types, and the round-robin
// helpers of the iSLIP crossbar scheduler.
// ----------------------------------------------------------------------------
package islip_pkg;

	localparam int PORTS   = 8;
	localparam int PTR_W   = $clog2(PORTS);
	localparam int MAT_W   = PORTS * PORTS;
	localparam int FIELD_W = 64;
	localparam int ITER_W  = 4;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [ITER_W-1:0] ITER_RESET    = 4'd4;
	localparam logic [ADDR_W-1:0] ADDR_MAX_ITER = 3'd0;

	typedef logic [PORTS-1:0] vec_t;
	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [MAT_W-1:0] mat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic round;
		logic first;
		logic publish;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic req_empty;
	} dp_status_t;

	// One-hot pick of the first set bit at or after ptr, wrapping around.
	function automatic vec_t rr_pick(vec_t bits, ptr_t ptr);
		vec_t pick;
		logic found;
		int   idx;
		pick  = '0;
		found = 1'b0;
		for (int k = 0; k < PORTS; k++) begin
			idx = int'(ptr) + k;
			if (idx >= PORTS) begin
				idx = idx - PORTS;
			end
			if (!found && bits[idx]) begin
				pick[idx] = 1'b1;
				found     = 1'b1;
			end
		end
		return pick;
	endfunction

	// Index one past the set bit of a one-hot vector, modulo PORTS.
	function automatic ptr_t next_ptr(vec_t onehot);
		ptr_t nxt;
		nxt = '0;
		for (int k = 0; k < PORTS; k++) begin
			if (onehot[k]) begin
				nxt = (k + 1 == PORTS) ? ptr_t'(0) : ptr_t'(k + 1);
			end
		end
		return nxt;
	endfunction

endpackage

// ----- sv/islip_ctrl.sv -----
// ----------------------------------------------------------------------------
// islip_ctrl
// Sequencer for the iSLIP rounds, the round limit register and the output
// word handshake.
// ----------------------------------------------------------------------------
`include "islip_crossbar_scheduler_defines.svh"

module islip_ctrl
	import islip_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              match_valid,
	input  logic              match_stall,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output dp_cmd_t           cmd,
	input  dp_status_t        status
);

	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_RUN  = 1'b1;

	logic [0:0]        state_q;
	logic [ITER_W-1:0] round_q;
	logic [ITER_W-1:0] max_iter_q;
	logic              out_valid_q;
	logic              done_cond;
	logic              out_free;

	// A decision is finished once no requests remain or the limit is used up.
	assign done_cond = (state_q == S_RUN) && (status.req_empty || (round_q >= max_iter_q));
	assign out_free  = !out_valid_q || !match_stall;

	assign req_stall   = (state_q != S_IDLE);
	assign match_valid = out_valid_q;

	assign cmd.load    = req_valid && (state_q == S_IDLE);
	assign cmd.round   = (state_q == S_RUN) && !done_cond;
	assign cmd.first   = (round_q == '0);
	assign cmd.publish = done_cond && out_free;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MAX_ITER) ? DATA_W'(max_iter_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_RUN;
						round_q <= '0;
					end
				end
				S_RUN: begin
					if (cmd.round) begin
						round_q <= round_q + 1'b1;
					end
					if (cmd.publish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!match_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= ITER_RESET;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_MAX_ITER)) begin
			max_iter_q <= pwdata[ITER_W-1:0];
		end
	end

	`ISLIP_ASSERT_NEXT(ctrl_accept_starts, req_valid && !req_stall,
		(state_q == S_RUN) && (round_q == '0), "accepted word did not start a decision")
	`ISLIP_ASSERT_SAME(ctrl_round_bound, state_q == S_RUN, round_q <= max_iter_q,
		"round count passed the round limit")
	`ISLIP_ASSERT_NEXT(ctrl_publish_valid, cmd.publish, match_valid,
		"finished decision was not presented")

endmodule

// ----- sv/islip_dp.sv -----
// ----------------------------------------------------------------------------
// islip_dp
// Request and match registers, grant and accept arbiters, and the per-port
// round-robin pointers.
// ----------------------------------------------------------------------------
`include "islip_crossbar_scheduler_defines.svh"

module islip_dp
	import islip_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	input  logic [FIELD_W-1:0] request_matrix,
	output logic [FIELD_W-1:0] match_matrix
);

	mat_t req_q;
	mat_t match_q;
	mat_t out_q;
	ptr_t gptr_q [PORTS];
	ptr_t aptr_q [PORTS];

	mat_t grant;
	mat_t acc;
	mat_t clear_mask;
	vec_t row_hit;
	vec_t col_hit;
	vec_t acc_row [PORTS];
	vec_t acc_col [PORTS];

	// Grant: each output picks among the inputs requesting it.
	always_comb begin
		vec_t col;
		vec_t g;
		grant = '0;
		for (int j = 0; j < PORTS; j++) begin
			for (int i = 0; i < PORTS; i++) begin
				col[i] = req_q[i*PORTS + j];
			end
			g = rr_pick(col, gptr_q[j]);
			for (int i = 0; i < PORTS; i++) begin
				grant[i*PORTS + j] = g[i];
			end
		end
	end

	// Accept: each input picks among the outputs that granted it. An output
	// grants at most one input, so the inputs never compete.
	always_comb begin
		acc = '0;
		for (int i = 0; i < PORTS; i++) begin
			acc_row[i]            = rr_pick(grant[i*PORTS +: PORTS], aptr_q[i]);
			acc[i*PORTS +: PORTS] = acc_row[i];
		end
	end

	always_comb begin
		row_hit = '0;
		col_hit = '0;
		for (int j = 0; j < PORTS; j++) begin
			acc_col[j] = '0;
		end
		for (int i = 0; i < PORTS; i++) begin
			row_hit[i] = |acc_row[i];
			for (int j = 0; j < PORTS; j++) begin
				acc_col[j][i] = acc_row[i][j];
				col_hit[j]    = col_hit[j] | acc_row[i][j];
			end
		end
		clear_mask = '0;
		for (int i = 0; i < PORTS; i++) begin
			for (int j = 0; j < PORTS; j++) begin
				clear_mask[i*PORTS + j] = row_hit[i] | col_hit[j];
			end
		end
	end

	assign status.req_empty = (req_q == '0);
	assign match_matrix     = FIELD_W'(out_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= request_matrix[MAT_W-1:0];
			match_q <= '0;
		end else if (cmd.round) begin
			req_q   <= req_q & ~clear_mask;
			match_q <= match_q | acc;
		end
		if (cmd.publish) begin
			out_q <= match_q;
		end
	end

	// Pointers move only on matches of the first round.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PORTS; k++) begin
				gptr_q[k] <= '0;
				aptr_q[k] <= '0;
			end
		end else if (cmd.round && cmd.first) begin
			for (int k = 0; k < PORTS; k++) begin
				if (row_hit[k]) begin
					aptr_q[k] <= next_ptr(acc_row[k]);
				end
				if (col_hit[k]) begin
					gptr_q[k] <= next_ptr(acc_col[k]);
				end
			end
		end
	end

	`ISLIP_ASSERT_SAME(dp_disjoint, $past(cmd.round), (req_q & match_q) == '0,
		"matched pair still present in the request set")

endmodule

// ----- sv/islip_crossbar_scheduler.sv -----
// ----------------------------------------------------------------------------
// islip_crossbar_scheduler
// iSLIP scheduler for a PORTS x PORTS crossbar.
// A request word enters on req_valid/req_stall with one bit per input and
// output pair. The block runs request-grant-accept rounds until no request
// is left or max_iterations rounds have run, then offers the match word on
// match_valid/match_stall. Each round is one pass through the grant and accept
// arbiters; the number of rounds run is at most max_iterations and at most
// PORTS. A new word is taken once the previous decision has been moved to the
// output register, even while that word is still stalled; a finished decision
// waits for the output register to free up. Reset clears all grant and accept
// pointers, sets max_iterations to four and empties the output. max_iterations
// is written over the APB port at address 0; the user must write it only while
// the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module islip_crossbar_scheduler
	import islip_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [FIELD_W-1:0] request_matrix,
	output logic               match_valid,
	input  logic               match_stall,
	output logic [FIELD_W-1:0] match_matrix,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	dp_cmd_t    cmd;
	dp_status_t status;

	islip_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.match_valid (match_valid),
		.match_stall (match_stall),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.cmd         (cmd),
		.status      (status)
	);

	islip_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.request_matrix (request_matrix),
		.match_matrix   (match_matrix)
	);

endmodule

// ----- tb/sv/tb_islip_crossbar_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_islip_crossbar_scheduler
// Self-checking bench for the iSLIP crossbar scheduler. Request words go in
// through the valid/stall channel, and each one is predicted by a software copy
// of the grant and accept pointers. The bench then checks every match word in
// order. The round limit is swept over the APB port between phases, and both
// channels stall at random.
// ----------------------------------------------------------------------------

import islip_pkg::*;

class islip_matches;
	ptr_t               accept_ptr [PORTS];
	ptr_t               grant_ptr [PORTS];
	logic [ITER_W-1:0]  round_limit;
	logic [FIELD_W-1:0] pending_matches [$];
	int                 mismatches;
	int                 words_checked;

	function new();
		foreach (accept_ptr[k]) begin
			accept_ptr[k] = '0;
			grant_ptr[k]  = '0;
		end
		round_limit   = ITER_RESET;
		mismatches    = 0;
		words_checked = 0;
	endfunction

	task flag_mismatch(string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// One scheduling decision. Pointers move only on first-round matches, and
	// later rounds already see the grant pointers moved by the first one.
	function logic [FIELD_W-1:0] schedule(logic [FIELD_W-1:0] requests);
		logic [FIELD_W-1:0] req;
		logic [FIELD_W-1:0] grant;
		logic [FIELD_W-1:0] match;
		int                 rounds;
		int                 cand;
		bit                 found;
		req    = requests;
		match  = '0;
		rounds = 0;
		while (req != '0 && rounds < int'(round_limit)) begin
			rounds++;
			grant = '0;
			for (int col = 0; col < PORTS; col++) begin
				found = 1'b0;
				for (int k = 0; k < PORTS; k++) begin
					cand = (k + int'(grant_ptr[col])) % PORTS;
					if (!found && req[cand*PORTS+col]) begin
						grant[cand*PORTS+col] = 1'b1;
						found                 = 1'b1;
					end
				end
			end
			for (int row = 0; row < PORTS; row++) begin
				found = 1'b0;
				for (int k = 0; k < PORTS; k++) begin
					cand = (k + int'(accept_ptr[row])) % PORTS;
					if (!found && grant[row*PORTS+cand]) begin
						found                 = 1'b1;
						match[row*PORTS+cand] = 1'b1;
						for (int t = 0; t < PORTS; t++) begin
							req[row*PORTS+t]  = 1'b0;
							req[t*PORTS+cand] = 1'b0;
						end
						if (rounds == 1) begin
							accept_ptr[row] = ptr_t'((cand + 1) % PORTS);
							grant_ptr[cand] = ptr_t'((row + 1) % PORTS);
						end
					end
				end
			end
		end
		return match;
	endfunction

	function void take_request(logic [FIELD_W-1:0] requests);
		pending_matches.insert(pending_matches.size(), schedule(requests));
	endfunction

	task check_match(logic [FIELD_W-1:0] got);
		logic [FIELD_W-1:0] want;
		if (pending_matches.size() == 0) begin
			flag_mismatch($sformatf("match word %016h with nothing outstanding", got));
		end else begin
			want = pending_matches.pop_front();
			words_checked++;
			if (got !== want) begin
				flag_mismatch($sformatf("match_matrix %016h, predicted %016h", got, want));
			end
		end
	endtask
endclass

module tb_islip_crossbar_scheduler;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int PHASE_WORDS    = 72;
	localparam int PHASES         = 10;
	localparam int OPENING_WORDS  = 20;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               req_valid      = 1'b0;
	logic               req_stall;
	logic [FIELD_W-1:0] request_matrix = '0;
	logic               match_valid;
	logic               match_stall    = 1'b0;
	logic [FIELD_W-1:0] match_matrix;
	logic               psel           = 1'b0;
	logic               penable        = 1'b0;
	logic               pwrite         = 1'b0;
	logic [ADDR_W-1:0]  paddr          = '0;
	logic [DATA_W-1:0]  pwdata         = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	bit                 sender_calm    = 1'b0;
	bit                 receiver_calm  = 1'b0;
	int                 words_sent     = 0;
	islip_matches       board          = new();

	islip_crossbar_scheduler u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.request_matrix (request_matrix),
		.match_valid    (match_valid),
		.match_stall    (match_stall),
		.match_matrix   (match_matrix),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Match channel: check each accepted word, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && match_valid && !match_stall) begin
			board.check_match(match_matrix);
		end
		match_stall <= !receiver_calm && ($urandom_range(99) < 38);
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && !req_stall) || (match_valid && !match_stall)
					|| psel) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("simulation failed");
		$finish;
	end

	task automatic send_request(input logic [FIELD_W-1:0] word);
		while (!sender_calm && $urandom_range(99) < 38) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid      <= 1'b1;
		request_matrix <= word;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		board.take_request(word);
		words_sent++;
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (board.pending_matches.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the round limit, then read it back in a second transfer.
	task automatic set_round_limit(input logic [ITER_W-1:0] limit);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_MAX_ITER;
		pwdata  <= DATA_W'(limit);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		board.round_limit = limit;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (prdata[ITER_W-1:0] !== limit) begin
			board.flag_mismatch($sformatf("max_iterations reads %0h, written %0h",
				prdata[ITER_W-1:0], limit));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [FIELD_W-1:0] pick_request();
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
		logic [FIELD_W-1:0] word;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		case ($urandom_range(7))
			0: begin
				word = '0;
				repeat ($urandom_range(1, 5)) word[$urandom_range(FIELD_W-1)] = 1'b1;
			end
			1: word = a & b;
			2: word = a;
			3: word = a | b;
			4: word = a & b & {$urandom, $urandom};
			5: word = '1;
			// Every input asks for the same set of outputs.
			6: word = {PORTS{a[PORTS-1:0]}};
			default: begin
				word = '0;
				word[$urandom_range(PORTS-1)*PORTS +: PORTS] = a[PORTS-1:0];
			end
		endcase
		return word;
	endfunction

	initial begin : stimulus
		logic [FIELD_W-1:0] opening [OPENING_WORDS];
		int                 limits [PHASES];
		opening = '{
			64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h1, 64'h8000_0000_0000_0000,
			64'h0000_0000_0000_00FF, 64'h0101_0101_0101_0101,
			64'h8040_2010_0804_0201, 64'h0102_0408_1020_4080,
			64'hFF00_0000_0000_0000, 64'h8080_8080_8080_8080,
			64'hAA55_AA55_AA55_AA55, 64'h55AA_55AA_55AA_55AA,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0F0F_0F0F_F0F0_F0F0, 64'hFFFF_FFFF_0000_0000,
			64'h0000_0000_FFFF_FFFF, 64'h0303_0303_0303_0303,
			64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE
		};
		limits    = '{1, 8, 0, 15, 2, 9, 3, 5, 7, 4};
		limits[7] = $urandom_range(1, 8);
		limits[8] = $urandom_range(1, 8);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limit of four rounds; a full matrix right after reset needs
		// every round available.
		foreach (opening[n]) begin
			send_request(opening[n]);
		end
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			set_round_limit(ITER_W'(limits[p]));
			sender_calm   = (p == 5);
			receiver_calm = (p == 5);
			repeat (PHASE_WORDS) send_request(pick_request());
			wait_idle();
		end

		foreach (board.pending_matches[n]) begin
			board.flag_mismatch($sformatf("predicted match %016h never came out",
				board.pending_matches[n]));
		end
		$display("Covered %0d request words over %0d round limits,", words_sent,
			PHASES + 1);
		$display("zero and above range included; compared %0d match words, %0d mismatches.",
			board.words_checked, board.mismatches);
		if (board.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
